/* hdl/actuator_setpoint_safety_gate_assert.svh */
// assertion helpers for the setpoint safety gate
`ifndef ACTUATOR_SETPOINT_SAFETY_GATE_ASSERT_SVH
`define ACTUATOR_SETPOINT_SAFETY_GATE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define ASG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("safety gate check failed");

// next-cycle implication, disabled while in reset
`define ASG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("safety gate check failed");

`endif

/* hdl/asg_pkg.sv */
package asg_pkg;

    localparam int SLOTS_DEFAULT = 8;
    localparam int MAX_SLOTS     = 8;
    localparam int IDX_W         = 3;
    localparam int TIME_W        = 48;
    localparam int CFG_W         = 64;
    localparam int CFG_IDX_W     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_MINIMUMS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_MAXIMUMS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_DEFAULTS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_MODE        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_TIMEOUT = 3'd4;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 48'd500000;

    localparam logic       OP_COMMAND  = 1'b0;
    localparam logic       OP_TICK     = 1'b1;
    localparam logic [1:0] SRC_RC      = 2'd0;
    localparam logic [1:0] SRC_INVALID = 2'd3;

    typedef struct packed {
        logic              operation;
        logic [TIME_W-1:0] now;
        logic [3:0]        slot;
        logic [7:0]        value;
        logic [1:0]        source;
        logic [TIME_W-1:0] command_time;
        logic              armed_seen;
        logic              armed;
        logic              safety_block;
        logic [7:0]        rc_valid_mask;
    } in_t;

    typedef struct packed {
        logic        accepted;
        logic        changed;
        logic [63:0] slot_values;
        logic [7:0]  slot_valid_mask;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_TICK,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic             load_in;
        logic             cmd_eval;
        logic             tick_eval;
        logic [IDX_W-1:0] tick_idx;
        logic             load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic is_tick;
    } dp_status_t;

    // invalid limits open the range to the full byte
    function automatic logic [7:0] clamp_byte(input logic [7:0] v,
                                              input logic [7:0] lo,
                                              input logic [7:0] hi);
        logic [7:0] l;
        logic [7:0] h;
        logic [7:0] r;
        l = (lo <= hi) ? lo : 8'd0;
        h = (lo <= hi) ? hi : 8'hff;
        r = v;
        if (r < l) r = l;
        if (r > h) r = h;
        return r;
    endfunction

    function automatic logic fresh_time(input logic [TIME_W-1:0] t,
                                        input logic [TIME_W-1:0] now,
                                        input logic [TIME_W-1:0] timeout);
        logic [TIME_W-1:0] age;
        age = now - t;
        return (t != '0) && (t <= now) && (age <= timeout);
    endfunction

endpackage

/* hdl/asg_ctrl.sv */
module asg_ctrl #(
    parameter int SLOTS = asg_pkg::SLOTS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  asg_pkg::dp_status_t   status,
    output asg_pkg::dp_cmd_t      cmd
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    asg_pkg::state_t   state_reg;
    asg_pkg::state_t   state_next;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] idx_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= asg_pkg::ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cmd          = '0;
        cmd.tick_idx = asg_pkg::IDX_W'(idx_reg);
        in_stall     = (state_reg != asg_pkg::ST_IDLE);
        // result leaves on transfer
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            asg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = asg_pkg::ST_DISPATCH;
                end
            end
            asg_pkg::ST_DISPATCH:
            begin
                if (status.is_tick)
                begin
                    idx_next   = '0;
                    state_next = asg_pkg::ST_TICK;
                end
                else
                begin
                    cmd.cmd_eval = 1'b1;
                    state_next   = asg_pkg::ST_LOAD;
                end
            end
            asg_pkg::ST_TICK:
            begin
                cmd.tick_eval = 1'b1;
                if (idx_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = asg_pkg::ST_LOAD;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            asg_pkg::ST_LOAD:
            begin
                // wait for the previous result to leave
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = asg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = asg_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

/* hdl/asg_dp.sv */
module asg_dp #(
    parameter int SLOTS = asg_pkg::SLOTS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  asg_pkg::in_t                    in_data,
    input  logic                            cfg_we,
    input  logic [asg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [asg_pkg::CFG_W-1:0]       cfg_data,
    input  asg_pkg::dp_cmd_t                cmd,
    output asg_pkg::dp_status_t             status,
    output asg_pkg::out_t                   out_data
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    asg_pkg::in_t                  in_reg;
    asg_pkg::out_t                 out_reg;
    logic                          accepted_reg;
    logic                          changed_reg;

    logic [63:0]                   min_reg;
    logic [63:0]                   max_reg;
    logic [63:0]                   dflt_reg;
    logic                          arm_mode_reg;
    logic [asg_pkg::TIME_W-1:0]    timeout_reg;

    logic [7:0]                    sp_value_reg [SLOTS];
    logic                          sp_valid_reg [SLOTS];
    logic [1:0]                    last_src_reg [SLOTS];
    logic [7:0]                    last_val_reg [SLOTS];
    logic [asg_pkg::TIME_W-1:0]    last_time_reg [SLOTS];

    logic [asg_pkg::IDX_W-1:0]     sel;
    logic [SLOT_W-1:0]             tick_addr;
    logic [SLOT_W-1:0]             cmd_addr;
    logic [7:0]                    lo;
    logic [7:0]                    hi;
    logic                          lim_ok;
    logic                          cmd_ok;
    logic                          rc_src;
    logic                          rc_ok;
    logic                          allowed;
    logic                          tick_valid;
    logic [7:0]                    tick_value;
    logic                          tick_diff;
    logic [63:0]                   values_packed;
    logic [7:0]                    valid_packed;

    assign status.is_tick = (in_reg.operation == asg_pkg::OP_TICK);

    assign tick_addr = cmd.tick_idx[SLOT_W-1:0];
    assign cmd_addr  = in_reg.slot[SLOT_W-1:0];
    assign sel       = cmd.tick_eval ? cmd.tick_idx : in_reg.slot[asg_pkg::IDX_W-1:0];
    assign lo        = min_reg[{sel, 3'b000} +: 8];
    assign hi        = max_reg[{sel, 3'b000} +: 8];
    assign lim_ok    = (lo <= hi);

    always_comb
    begin
        cmd_ok = (32'(in_reg.slot) < SLOTS)
            && (in_reg.source != asg_pkg::SRC_INVALID)
            && in_reg.armed_seen && !in_reg.safety_block
            && lim_ok
            && asg_pkg::fresh_time(in_reg.command_time, in_reg.now, timeout_reg)
            && ((in_reg.source != asg_pkg::SRC_RC) || in_reg.rc_valid_mask[sel])
            && (in_reg.armed || (arm_mode_reg && (in_reg.source == asg_pkg::SRC_RC)));
    end

    // per-slot policy check for one tick step
    always_comb
    begin
        rc_src     = (last_src_reg[tick_addr] == asg_pkg::SRC_RC);
        rc_ok      = rc_src && in_reg.rc_valid_mask[sel];
        allowed    = in_reg.armed_seen && !in_reg.safety_block
                     && (in_reg.armed || (arm_mode_reg && rc_ok));
        tick_valid = sp_valid_reg[tick_addr] && lim_ok && allowed
                     && asg_pkg::fresh_time(last_time_reg[tick_addr], in_reg.now, timeout_reg)
                     && (!rc_src || rc_ok);
        tick_value = asg_pkg::clamp_byte(tick_valid ? last_val_reg[tick_addr]
                                                    : dflt_reg[{sel, 3'b000} +: 8], lo, hi);
        tick_diff  = (sp_valid_reg[tick_addr] != tick_valid)
                     || (sp_value_reg[tick_addr] != tick_value);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg <= in_data;
        end
        if (cmd.load_out)
        begin
            out_reg.accepted        <= accepted_reg;
            out_reg.changed         <= changed_reg;
            out_reg.slot_values     <= values_packed;
            out_reg.slot_valid_mask <= valid_packed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_reg <= 1'b0;
            changed_reg  <= 1'b0;
        end
        else if (cmd.load_in)
        begin
            accepted_reg <= 1'b0;
            changed_reg  <= 1'b0;
        end
        else if (cmd.cmd_eval)
        begin
            accepted_reg <= cmd_ok;
            changed_reg  <= cmd_ok;
        end
        else if (cmd.tick_eval)
        begin
            changed_reg <= changed_reg || tick_diff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg      <= '0;
            max_reg      <= '1;
            dflt_reg     <= '0;
            arm_mode_reg <= 1'b0;
            timeout_reg  <= asg_pkg::TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                asg_pkg::CFG_SLOT_MINIMUMS:   min_reg      <= cfg_data;
                asg_pkg::CFG_SLOT_MAXIMUMS:   max_reg      <= cfg_data;
                asg_pkg::CFG_SLOT_DEFAULTS:   dflt_reg     <= cfg_data;
                asg_pkg::CFG_ARM_MODE:        arm_mode_reg <= cfg_data[0];
                asg_pkg::CFG_COMMAND_TIMEOUT: timeout_reg  <= cfg_data[asg_pkg::TIME_W-1:0];
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                sp_value_reg[i] <= '0;
                sp_valid_reg[i] <= 1'b0;
            end
        end
        else if (cmd.cmd_eval && cmd_ok)
        begin
            sp_value_reg[cmd_addr] <= asg_pkg::clamp_byte(in_reg.value, lo, hi);
            sp_valid_reg[cmd_addr] <= 1'b1;
        end
        else if (cmd.tick_eval)
        begin
            sp_value_reg[tick_addr] <= tick_value;
            sp_valid_reg[tick_addr] <= tick_valid;
        end
    end

    // command history is only read behind a set valid bit
    always_ff @(posedge clk)
    begin
        if (cmd.cmd_eval && cmd_ok)
        begin
            last_src_reg[cmd_addr]  <= in_reg.source;
            last_val_reg[cmd_addr]  <= in_reg.value;
            last_time_reg[cmd_addr] <= in_reg.command_time;
        end
    end

    for (genvar g = 0; g < asg_pkg::MAX_SLOTS; g++)
    begin : g_pack
        if (g < SLOTS)
        begin : g_used
            assign values_packed[8*g +: 8] = sp_value_reg[g];
            assign valid_packed[g]         = sp_valid_reg[g];
        end
        else
        begin : g_unused
            assign values_packed[8*g +: 8] = 8'd0;
            assign valid_packed[g]         = 1'b0;
        end
    end

    assign out_data = out_reg;

endmodule

/* hdl/actuator_setpoint_safety_gate.sv */
// channel   direction   handshake             payload
// in        input       in_valid / in_stall   asg_pkg::in_t (command or tick)
// out       output      out_valid / out_stall asg_pkg::out_t (one result per item)
// cfg       input       cfg_we                cfg_index, cfg_data (write only)
//
// a command goes from the dispatch state to the load state; a tick runs the tick loop between them,
// and the tick loop checks one slot per cycle through the shared policy logic
// the input reopens the cycle after the load, so a new item is taken only once the last one is loaded
// reset clears the setpoint table and valid bits, and restores register defaults
// a new item is taken while the previous result waits; a stalled output holds the
// next item in the load state until the waiting result transfers
`include "actuator_setpoint_safety_gate_assert.svh"

module actuator_setpoint_safety_gate #(
    parameter int SLOTS = asg_pkg::SLOTS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  asg_pkg::in_t                    in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output asg_pkg::out_t                   out_data,
    input  logic                            cfg_we,
    input  logic [asg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [asg_pkg::CFG_W-1:0]       cfg_data
);

    asg_pkg::dp_cmd_t    cmd;
    asg_pkg::dp_status_t status;

    asg_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    asg_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

    `ASG_ASSERT_IMPLY(a_accept_changes, clk, rst_n, out_valid && out_data.accepted, out_data.changed)
    `ASG_ASSERT_IMPLY(a_unused_slots_invalid, clk, rst_n, out_valid, (16'(out_data.slot_valid_mask) >> SLOTS) == 16'd0)
    `ASG_ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, in_valid && !in_stall, in_stall)

endmodule
